/* sv/lass_pkg.sv */
package lass_pkg;

	localparam int SYM_W   = 8;
	localparam int SCORE_W = 10;
	localparam int POS_W   = 32;
	localparam int QIDX_W  = 6;
	localparam int QLEN_W  = 7;
	localparam int PEN_W   = 4;
	localparam int CFG_W   = 7;
	localparam int SUM_W   = 12;

	localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
	localparam logic [POS_W-1:0]   POS_MAX   = '1;

	localparam logic [QLEN_W-1:0] QLEN_RST     = 7'd1;
	localparam logic [PEN_W-1:0]  MATCH_RST    = 4'd3;
	localparam logic [PEN_W-1:0]  MISMATCH_RST = 4'd3;
	localparam logic [PEN_W-1:0]  GAP_RST      = 4'd2;

	typedef enum logic [1:0] {
		REG_QUERY_LENGTH = 2'd0,
		REG_MATCH        = 2'd1,
		REG_MISMATCH     = 2'd2,
		REG_GAP          = 2'd3
	} reg_index_t;

	typedef enum logic {
		KIND_QUERY = 1'b0,
		KIND_DB    = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [SYM_W-1:0]   symbol;
		logic [QIDX_W-1:0]  query_index;
		logic               last;
	} item_t;

	typedef struct packed {
		logic [SCORE_W-1:0] best_score;
		logic               found;
		logic [QIDX_W-1:0]  best_query_pos;
		logic [POS_W-1:0]   best_db_pos;
	} result_t;

	typedef struct packed {
		logic [QLEN_W-1:0] query_length;
		logic [PEN_W-1:0]  match_score;
		logic [PEN_W-1:0]  mismatch_penalty;
		logic [PEN_W-1:0]  gap_penalty;
	} cfg_t;

	// One database column travelling down the row of cells.
	typedef struct packed {
		logic               valid;
		logic               last;
		logic [SYM_W-1:0]   sym;
		logic [POS_W-1:0]   pos;
		logic [SCORE_W-1:0] up;
		logic [SCORE_W-1:0] tok_val;
		logic [POS_W-1:0]   tok_col;
	} wave_t;

endpackage

/* sv/local_alignment_score_search.sv */
// Channel  | Direction | Word     | Handshake
// item     | in        | item_t   | item_valid / item_stall
// result   | out       | result_t | result_valid / result_stall
// config   | in        | 7 bits   | cfg_we, cfg_index
//
// Database words enter one per cycle while item_stall is low and walk a row of
// QUERY_MAX cells, one cell a cycle. A result is registered from the far end of the
// row once its last word has passed every cell, so the row length sets its delay.
// After a last word, item_stall stays high until the result word has been taken.
// A query word stalls while the busy counter, reloaded by each database word, is nonzero.
// Reset clears cell scores, best cell and position counter; registers get their defaults.
module local_alignment_score_search
	import lass_pkg::*;
#(
	parameter int QUERY_MAX = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  item_t            item_word,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result_word,
	input  logic             cfg_we,
	input  reg_index_t       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int RW = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
	localparam int CW = $clog2(QUERY_MAX + 1);

	cfg_t             cfg_q;
	logic [POS_W-1:0] pos_q;
	logic [CW-1:0]    busy_q;
	logic             pend_q;
	logic             out_valid_q;
	result_t          out_q;

	logic acc, db_acc, q_acc, out_acc;

	wave_t         wv [QUERY_MAX+1];
	logic [RW-1:0] rw [QUERY_MAX+1];

	always_comb begin
		item_stall = pend_q || ((item_word.kind == KIND_QUERY) && (busy_q != '0));
		acc = item_valid && !item_stall;
		db_acc = acc && (item_word.kind == KIND_DB);
		q_acc = acc && (item_word.kind == KIND_QUERY);
		out_acc = out_valid_q && !result_stall;
		wv[0].valid   = db_acc;
		wv[0].last    = item_word.last;
		wv[0].sym     = item_word.symbol;
		wv[0].pos     = pos_q;
		wv[0].up      = '0;
		wv[0].tok_val = '0;
		wv[0].tok_col = '0;
		rw[0] = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.query_length     <= QLEN_RST;
			cfg_q.match_score      <= MATCH_RST;
			cfg_q.mismatch_penalty <= MISMATCH_RST;
			cfg_q.gap_penalty      <= GAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_QUERY_LENGTH: cfg_q.query_length     <= cfg_data;
				REG_MATCH:        cfg_q.match_score      <= cfg_data[PEN_W-1:0];
				REG_MISMATCH:     cfg_q.mismatch_penalty <= cfg_data[PEN_W-1:0];
				REG_GAP:          cfg_q.gap_penalty      <= cfg_data[PEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			busy_q      <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (db_acc) begin
				if (item_word.last) begin
					pos_q <= '0;
				end else if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 1'b1;
				end
				busy_q <= CW'(QUERY_MAX - 1);
			end else if (busy_q != '0) begin
				busy_q <= busy_q - 1'b1;
			end
			if (db_acc && item_word.last) begin
				pend_q <= 1'b1;
			end else if (out_acc) begin
				pend_q <= 1'b0;
			end
			if (wv[QUERY_MAX].valid && wv[QUERY_MAX].last) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wv[QUERY_MAX].valid && wv[QUERY_MAX].last) begin
			out_q.best_score     <= wv[QUERY_MAX].tok_val;
			out_q.found          <= wv[QUERY_MAX].tok_val != '0;
			out_q.best_query_pos <= QIDX_W'(rw[QUERY_MAX]);
			out_q.best_db_pos    <= wv[QUERY_MAX].tok_col;
		end
	end

	for (genvar i = 0; i < QUERY_MAX; i++) begin : g_cell
		logic qwr;
		assign qwr = q_acc && (32'(item_word.query_index) == 32'(i));
		lass_cell #(
			.IDX (i),
			.RW  (RW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cfg     (cfg_q),
			.qwr     (qwr),
			.qsym    (item_word.symbol),
			.win     (wv[i]),
			.row_in  (rw[i]),
			.wout    (wv[i+1]),
			.row_out (rw[i+1])
		);
	end

	assign result_valid = out_valid_q;
	assign result_word  = out_q;

endmodule

/* sv/lass_cell.sv */
module lass_cell
	import lass_pkg::*;
#(
	parameter int IDX = 0,
	parameter int RW  = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          qwr,
	input  logic [SYM_W-1:0] qsym,
	input  wave_t         win,
	input  logic [RW-1:0] row_in,
	output wave_t         wout,
	output logic [RW-1:0] row_out
);

	logic [SYM_W-1:0]   qsym_q;
	logic [SCORE_W-1:0] left_q;
	logic [SCORE_W-1:0] diag_q;
	logic [SCORE_W-1:0] bval_q;
	logic [POS_W-1:0]   bcol_q;
	logic               valid_q;
	wave_t              wave_q;
	logic [RW-1:0]      row_q;

	logic               active;
	logic signed [SUM_W-1:0] d, l, u, hmax;
	logic [SCORE_W-1:0] h;
	logic               upd;
	logic [SCORE_W-1:0] nb_val;
	logic [POS_W-1:0]   nb_col;
	logic               take;

	always_comb begin
		active = win.valid && (32'(IDX) < 32'(cfg.query_length));
		d = $signed({2'b00, diag_q}) + ((qsym_q == win.sym)
			? $signed({8'b0, cfg.match_score})
			: -$signed({8'b0, cfg.mismatch_penalty}));
		l = $signed({2'b00, left_q}) - $signed({8'b0, cfg.gap_penalty});
		u = $signed({2'b00, win.up}) - $signed({8'b0, cfg.gap_penalty});
		hmax = '0;
		if (d > hmax) begin
			hmax = d;
		end
		if (l > hmax) begin
			hmax = l;
		end
		if (u > hmax) begin
			hmax = u;
		end
		if (!active) begin
			h = '0;
		end else if (hmax > $signed({2'b00, SCORE_MAX})) begin
			h = SCORE_MAX;
		end else begin
			h = hmax[SCORE_W-1:0];
		end
		upd = active && (h > bval_q);
		nb_val = upd ? h : bval_q;
		nb_col = upd ? win.pos : bcol_q;
		take = nb_val > win.tok_val;
	end

	always_ff @(posedge clk) begin
		if (qwr) begin
			qsym_q <= qsym;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			diag_q  <= '0;
			bval_q  <= '0;
			bcol_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= win.valid;
			if (win.valid) begin
				if (win.last) begin
					left_q <= '0;
					diag_q <= '0;
					bval_q <= '0;
					bcol_q <= '0;
				end else begin
					if (active) begin
						left_q <= h;
					end
					diag_q <= win.up;
					bval_q <= nb_val;
					bcol_q <= nb_col;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		wave_q.valid   <= win.valid;
		wave_q.last    <= win.last;
		wave_q.sym     <= win.sym;
		wave_q.pos     <= win.pos;
		wave_q.up      <= active ? h : left_q;
		wave_q.tok_val <= take ? nb_val : win.tok_val;
		wave_q.tok_col <= take ? nb_col : win.tok_col;
		row_q          <= take ? RW'(IDX) : row_in;
	end

	always_comb begin
		wout = wave_q;
		wout.valid = valid_q;
		row_out = row_q;
	end

endmodule

/* sv/lass_checker.sv */
module lass_checker
	import lass_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input item_t   item_word,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result_word
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_word))
		else $error("Stalled result word changed.");

	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_word.found == (result_word.best_score != '0))
		else $error("Found flag disagrees with the score.");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_word.found |->
			result_word.best_query_pos == '0 && result_word.best_db_pos == '0)
		else $error("Empty result carries a position.");

	a_pending_stall: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> item_stall)
		else $error("Input open while a result waits.");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item_word.kind == KIND_DB && item_word.last
			|=> !result_valid)
		else $error("Result appeared right after a last word.");

endmodule

bind local_alignment_score_search lass_checker u_lass_checker (.*);
